// File: rtl/bamd_pkg.sv
// ----------------------------------------------------------------------------
// bamd_pkg
// Shared widths, defaults and types of the block-average motion detector.
// ----------------------------------------------------------------------------
package bamd_pkg;

  // acceleration sample width per axis (signed milli-g)
  localparam int ACCEL_W       = 16;
  // motion level and threshold width
  localparam int MOTION_W      = 18;
  // number of axes per sample
  localparam int AXES          = 3;
  // default number of samples per block
  localparam int BLOCK_LEN_DEF = 4;

  // result of one processed sample, handed from the motion stage to the top
  typedef struct packed {
    logic                done;
    logic                act;
    logic [MOTION_W-1:0] level;
  } motion_res_t;

endpackage

// File: rtl/block_average_motion_detector_unit.sv
// ----------------------------------------------------------------------------
// block_average_motion_detector_unit
// Per-axis block averaging of acceleration samples, motion level against the
// previous block's averages and activity flag against a threshold register.
// ----------------------------------------------------------------------------
// A request passes through the input register, the block-sum register and the
// result register in that order before its result is on the master side.
// Throughput: one sample per cycle; input register, block-sum register and
// result register each stall only when the stage behind them is full.
// Reset (rst, synchronous): pipeline empty, sums, count, reference averages,
// motion level and threshold cleared; the first sample after reset primes the
// reference.
module block_average_motion_detector_unit #(
  parameter int BLOCK_LEN = bamd_pkg::BLOCK_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [bamd_pkg::MOTION_W-1:0] cfg_wdata,   // activity threshold
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,     // accel_x, accel_y, accel_z
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata      // block_done, activity_detected,
                                                     // motion_level, zero fill
);

  localparam int ACCEL_W = bamd_pkg::ACCEL_W;
  localparam int AXES    = bamd_pkg::AXES;
  localparam int CNT_W   = $clog2(BLOCK_LEN);
  localparam int SUM_W   = ACCEL_W + CNT_W;

  logic [bamd_pkg::MOTION_W-1:0]            threshold;

  // input register
  logic                                     in_v;
  logic [AXES-1:0][ACCEL_W-1:0]             in_acc;

  // block accumulation state
  logic [AXES-1:0][SUM_W-1:0]               sum;
  logic [AXES-1:0][SUM_W-1:0]               sum_next;
  logic [CNT_W-1:0]                         sample_count;
  logic                                     blk_last;
  logic                                     primed;

  // block-sum register
  logic                                     blk_v;
  logic                                     blk_done;
  logic [AXES-1:0]                          blk_neg;
  logic [AXES-1:0][SUM_W-1:0]               blk_mag;

  // reference and motion state
  logic [AXES-1:0][ACCEL_W-1:0]             ref_avg;
  logic [AXES-1:0][ACCEL_W-1:0]             avg;
  logic [bamd_pkg::MOTION_W-1:0]            last_motion;
  bamd_pkg::motion_res_t                    res;

  // result register
  logic                                     out_v;
  bamd_pkg::motion_res_t                    out_res;

  logic                                     en_in;
  logic                                     en_blk;
  logic                                     en_out;

  // stage enables: a stage loads when it is empty or its content moves on
  assign en_out   = !out_v || m_tready;
  assign en_blk   = !blk_v || en_out;
  assign en_in    = !in_v || en_blk;
  assign s_tready = en_in;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_wen) begin
      threshold <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en_in) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in && s_tvalid) begin
      in_acc[0] <= s_tdata[15:0];
      in_acc[1] <= s_tdata[31:16];
      in_acc[2] <= s_tdata[47:32];
    end
  end

  // running sums including the sample in the input register
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_next[a] = sum[a] + SUM_W'($signed(in_acc[a]));
    end
  end

  assign blk_last = (sample_count == CNT_W'(BLOCK_LEN - 1));

  // block accumulation and priming
  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      sample_count <= '0;
      primed       <= 1'b0;
    end else if (in_v && en_blk) begin
      primed <= 1'b1;
      if (blk_last) begin
        sum          <= '0;
        sample_count <= '0;
      end else begin
        sum          <= sum_next;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  // block-sum register: sign and magnitude of the running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_v <= 1'b0;
    end else if (en_blk) begin
      blk_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_blk && in_v) begin
      blk_done <= blk_last;
      for (int a = 0; a < AXES; a++) begin
        blk_neg[a] <= sum_next[a][SUM_W-1];
        blk_mag[a] <= sum_next[a][SUM_W-1] ? (SUM_W'(0) - sum_next[a]) : sum_next[a];
      end
    end
  end

  // average, change and compare
  bamd_motion #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_motion (
    .done        (blk_done),
    .sum_neg     (blk_neg),
    .sum_mag     (blk_mag),
    .ref_avg     (ref_avg),
    .threshold   (threshold),
    .last_motion (last_motion),
    .avg         (avg),
    .res         (res)
  );

  // reference averages: loaded at a block end, primed by the first sample
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_avg     <= '0;
      last_motion <= '0;
    end else if (blk_v && en_out && blk_done) begin
      ref_avg     <= avg;
      last_motion <= res.level;
    end else if (in_v && en_blk && !primed) begin
      ref_avg     <= in_acc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en_out) begin
      out_v <= blk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && blk_v) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {4'b0000, out_res.level, out_res.act, out_res.done};

  // activity is only ever reported on a block end
  a_act_needs_done : assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_res.done || !out_res.act))
    else $error("activity flagged without a completed block");

  // sample counter stays inside the block
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    32'(sample_count) < BLOCK_LEN)
    else $error("sample counter beyond block length");

  // once primed, the reference is never unprimed until reset
  a_primed_holds : assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped");

  // a block end never coincides with priming of the reference
  a_no_prime_at_end : assert property (@(posedge clk) disable iff (rst)
    (blk_v && blk_done) |-> primed)
    else $error("block end before reference was primed");

endmodule

// File: rtl/bamd_motion.sv
// ----------------------------------------------------------------------------
// bamd_motion
// Block average by reciprocal multiply, absolute change against the reference
// averages and threshold compare. Purely combinational; sits between the
// block-sum register and the result register of the top level.
// ----------------------------------------------------------------------------
module bamd_motion #(
  parameter int BLOCK_LEN = bamd_pkg::BLOCK_LEN_DEF
) (
  input  logic                                              done,
  input  logic [bamd_pkg::AXES-1:0]                         sum_neg,
  input  logic [bamd_pkg::AXES-1:0][bamd_pkg::ACCEL_W+$clog2(BLOCK_LEN)-1:0] sum_mag,
  input  logic [bamd_pkg::AXES-1:0][bamd_pkg::ACCEL_W-1:0]  ref_avg,
  input  logic [bamd_pkg::MOTION_W-1:0]                     threshold,
  input  logic [bamd_pkg::MOTION_W-1:0]                     last_motion,
  output logic [bamd_pkg::AXES-1:0][bamd_pkg::ACCEL_W-1:0]  avg,
  output bamd_pkg::motion_res_t                             res
);

  localparam int SUM_W    = bamd_pkg::ACCEL_W + $clog2(BLOCK_LEN);
  // shift chosen so that floor(n * RECIP >> RECIP_SH) == floor(n / BLOCK_LEN)
  // holds for every magnitude below 2**SUM_W
  localparam int RECIP_SH = SUM_W + $clog2(BLOCK_LEN);
  localparam int PROD_W   = SUM_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));
  localparam int Q_W      = bamd_pkg::ACCEL_W + 1;

  logic [bamd_pkg::AXES-1:0][PROD_W-1:0]            prod;
  logic [bamd_pkg::AXES-1:0][Q_W-1:0]               quot;
  logic [bamd_pkg::AXES-1:0][Q_W-1:0]               avg_wide;
  logic [bamd_pkg::AXES-1:0][Q_W-1:0]               diff;
  logic [bamd_pkg::AXES-1:0][Q_W-1:0]               diff_abs;
  logic [bamd_pkg::MOTION_W-1:0]                    level;

  // per-axis average (truncated toward zero) and absolute change
  always_comb begin
    for (int a = 0; a < bamd_pkg::AXES; a++) begin
      prod[a]     = PROD_W'(sum_mag[a]) * PROD_W'(RECIP);
      quot[a]     = prod[a][RECIP_SH +: Q_W];
      avg_wide[a] = sum_neg[a] ? (Q_W'(0) - quot[a]) : quot[a];
      avg[a]      = avg_wide[a][bamd_pkg::ACCEL_W-1:0];
      diff[a]     = {ref_avg[a][bamd_pkg::ACCEL_W-1], ref_avg[a]}
                  - {avg[a][bamd_pkg::ACCEL_W-1], avg[a]};
      diff_abs[a] = diff[a][Q_W-1] ? (Q_W'(0) - diff[a]) : diff[a];
    end
  end

  // motion level over the three axes
  assign level = bamd_pkg::MOTION_W'(diff_abs[0][bamd_pkg::ACCEL_W-1:0])
               + bamd_pkg::MOTION_W'(diff_abs[1][bamd_pkg::ACCEL_W-1:0])
               + bamd_pkg::MOTION_W'(diff_abs[2][bamd_pkg::ACCEL_W-1:0]);

  // result of this sample; level holds the last value between blocks
  assign res.done  = done;
  assign res.act   = done && (level > threshold);
  assign res.level = done ? level : last_motion;

endmodule

// File: test/tb_block_average_motion_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_block_average_motion_detector_unit
// Streams three-axis acceleration samples into the motion detector and checks
// every result against a cycle-free model of block averaging, motion level and
// the activity threshold, under several idling and back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_block_average_motion_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACCEL_W       = bamd_pkg::ACCEL_W;
  localparam int MOTION_W      = bamd_pkg::MOTION_W;
  localparam int BLOCK_SAMPLES = bamd_pkg::BLOCK_LEN_DEF;
  localparam int MAX_MOTION    = 196605;
  localparam int PIPE_SLACK    = 8;      // cycles allowed after the last result
  localparam int LONG_HOLD     = 300;    // receiver hold-off, in cycles
  localparam int ITEMS_PER_RUN = 360;

  typedef struct {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } accel_t;

  typedef struct {
    logic                done;
    logic                act;
    logic [MOTION_W-1:0] level;
  } motion_t;

  // DUT ports
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_wen   = 1'b0;
  logic [MOTION_W-1:0] cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [47:0]         s_tdata   = '0;     // accel_x, accel_y, accel_z
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [23:0]         m_tdata;           // block_done, activity_detected,
                                          // motion_level, zero fill

  // stimulus and expectation stores
  accel_t  accel_pending_q[$];
  motion_t motion_expect_q[$];

  // predictor state
  logic [MOTION_W-1:0] threshold_now = '0;
  int                  blk_sum_x, blk_sum_y, blk_sum_z;
  int                  blk_count;
  int                  ref_avg_x, ref_avg_y, ref_avg_z;
  logic                ref_loaded;
  logic [MOTION_W-1:0] motion_now;

  // idling controls, set by the sequencer between runs
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen;
  int   hold_left;

  // randomly relocated centre for well-formed sensor traces
  int base_x, base_y, base_z;
  int jitter;

  // bookkeeping
  int fail_count    = 0;
  int accepted_cnt  = 0;
  int result_cnt    = 0;
  int block_cnt     = 0;
  int active_cnt    = 0;

  block_average_motion_detector_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic int abs_diff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // advance the detector state by one sample and return its result
  function automatic motion_t predict_block_motion(input accel_t s);
    motion_t r;
    int      avg_x, avg_y, avg_z;
    if (!ref_loaded) begin
      ref_avg_x  = s.x;
      ref_avg_y  = s.y;
      ref_avg_z  = s.z;
      ref_loaded = 1'b1;
    end
    blk_sum_x += s.x;
    blk_sum_y += s.y;
    blk_sum_z += s.z;
    blk_count++;
    r.done = 1'b0;
    r.act  = 1'b0;
    if (blk_count >= BLOCK_SAMPLES) begin
      // signed division truncates toward zero
      avg_x = blk_sum_x / BLOCK_SAMPLES;
      avg_y = blk_sum_y / BLOCK_SAMPLES;
      avg_z = blk_sum_z / BLOCK_SAMPLES;
      motion_now = MOTION_W'(abs_diff(ref_avg_x, avg_x) + abs_diff(ref_avg_y, avg_y) +
                             abs_diff(ref_avg_z, avg_z));
      ref_avg_x = avg_x;
      ref_avg_y = avg_y;
      ref_avg_z = avg_z;
      blk_sum_x = 0;
      blk_sum_y = 0;
      blk_sum_z = 0;
      blk_count = 0;
      r.done = 1'b1;
      r.act  = (motion_now > threshold_now);
    end
    r.level = motion_now;
    return r;
  endfunction

  function automatic logic signed [ACCEL_W-1:0] clamp_accel(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[ACCEL_W-1:0];
  endfunction

  // mostly a noisy trace around a wandering centre, plus noise and extremes
  function automatic accel_t random_accel();
    accel_t s;
    int     r;
    r = $urandom_range(99);
    if (r < 8) begin
      base_x = $urandom_range(4000) - 2000;
      base_y = $urandom_range(4000) - 2000;
      base_z = $urandom_range(4000) - 2000;
    end
    if (r < 80) begin
      s.x = clamp_accel(base_x + $urandom_range(2 * jitter) - jitter);
      s.y = clamp_accel(base_y + $urandom_range(2 * jitter) - jitter);
      s.z = clamp_accel(base_z + $urandom_range(2 * jitter) - jitter);
    end else if (r < 93) begin
      s.x = ACCEL_W'($urandom);
      s.y = ACCEL_W'($urandom);
      s.z = ACCEL_W'($urandom);
    end else begin
      s.x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.z = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    return s;
  endfunction

  task automatic queue_accel(input int x, input int y, input int z);
    accel_t s;
    s.x = x[ACCEL_W-1:0];
    s.y = y[ACCEL_W-1:0];
    s.z = z[ACCEL_W-1:0];
    accel_pending_q.push_back(s);
  endtask

  task automatic queue_block(input int x, input int y, input int z);
    repeat (BLOCK_SAMPLES) queue_accel(x, y, z);
  endtask

  // block until every queued request has gone through and every result is back
  task automatic wait_drained();
    @(negedge clk);
    while (accel_pending_q.size() != 0 || s_tvalid || motion_expect_q.size() != 0)
      @(negedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [MOTION_W-1:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    threshold_now = value;
  endtask

  // request driver: predicts on acceptance, then offers the next sample
  always @(posedge clk) begin
    accel_t  s;
    motion_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        s.x = s_tdata[15:0];
        s.y = s_tdata[31:16];
        s.z = s_tdata[47:32];
        r = predict_block_motion(s);
        motion_expect_q.push_back(r);
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (accel_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s = accel_pending_q.pop_front();
          s_tdata  <= {s.z, s.y, s.x};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD - 1;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    motion_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_cnt++;
      if (motion_expect_q.size() == 0) begin
        report_mismatch("unexpected result, data", m_tdata, 0);
      end else begin
        want = motion_expect_q.pop_front();
        if (m_tdata[0] !== want.done) report_mismatch("block_done", m_tdata[0], want.done);
        if (m_tdata[1] !== want.act)
          report_mismatch("activity_detected", m_tdata[1], want.act);
        if (m_tdata[19:2] !== want.level)
          report_mismatch("motion_level", m_tdata[19:2], want.level);
        if (m_tdata[23:20] !== 4'b0) report_mismatch("zero fill", m_tdata[23:20], 0);
      end
      if (m_tdata[0] === 1'b1) block_cnt++;
      if (m_tdata[1] === 1'b1) active_cnt++;
    end
  end

  // sequencer
  initial begin
    int send_pct[4];
    int recv_pct[4];
    logic [MOTION_W-1:0] thr[4];

    ref_loaded = 1'b0;
    blk_sum_x = 0;  blk_sum_y = 0;  blk_sum_z = 0;  blk_count = 0;
    ref_avg_x = 0;  ref_avg_y = 0;  ref_avg_z = 0;
    motion_now = '0;
    base_x = 0;  base_y = 0;  base_z = 1000;
    jitter = 200;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: priming, full-scale swing, truncation toward zero
    write_threshold('0);
    @(negedge clk);
    queue_block(32767, 32767, 32767);        // primes reference, motion 0
    queue_block(-32768, -32768, -32768);     // largest motion level
    queue_accel(-1, 1, -3);                  // negative sums truncate toward zero
    queue_accel(0, 1, -3);
    queue_accel(0, 1, -3);
    queue_accel(0, 0, -2);
    queue_accel(16'h5555, 16'haaaa, 16'h5555);
    queue_accel(16'haaaa, 16'h5555, 16'haaaa);
    queue_accel(16'h5555, 16'haaaa, 16'h5555);
    queue_accel(16'haaaa, 16'h5555, 16'haaaa);
    wait_drained();

    // threshold at the top of the motion range: never exceeded
    write_threshold(MOTION_W'(MAX_MOTION));
    @(negedge clk);
    queue_block(32767, 32767, 32767);
    wait_drained();

    // one below: exceeded by a full swing
    write_threshold(MOTION_W'(MAX_MOTION - 1));
    @(negedge clk);
    queue_block(-32768, -32768, -32768);
    wait_drained();

    // random runs, one per idling pattern
    send_pct = '{0, 55, 0, 15};
    recv_pct = '{0, 0, 55, 15};
    thr[0] = MOTION_W'($urandom_range(1500));
    thr[1] = '1;
    thr[2] = '0;
    thr[3] = MOTION_W'($urandom_range(MAX_MOTION));
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr[ph]);
      jitter = (ph == 0) ? 200 : $urandom_range(50, 800);
      @(negedge clk);
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      repeat (ITEMS_PER_RUN) accel_pending_q.push_back(random_accel());
      // back-pressure the whole pipe while the sender keeps offering
      if (ph == 0) hold_req = ~hold_req;
      wait_drained();
    end

    $display("Covered %0d samples in %0d blocks, %0d flagged active, %0d results checked",
             accepted_cnt, block_cnt, active_cnt, result_cnt);
    $display("Thresholds included 0, 196604, 196605 and all ones; four idling patterns");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d results still expected", motion_expect_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
